/* design/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. Assertions are clocked on clock.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset only
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checked on every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* design/pospid_pkg.sv */
// ---------------------------------------------------------------------------
// pospid_pkg
// Types and constants shared by the position PID modules.
// ---------------------------------------------------------------------------
package pospid_pkg;

   localparam int DATA_W    = 32;
   localparam int LIMIT_W   = 31;
   localparam int CSR_IDX_W = 3;
   localparam int DIFF_W    = DATA_W + 1;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int PROD_D_W  = DATA_W + DIFF_W;
   localparam int SUM_W     = PROD_D_W + 2;
   localparam int FRAC_DROP = 16;
   localparam int SHIFT_W   = SUM_W - FRAC_DROP;

   localparam logic [DATA_W-1:0]  TARGET_RST   = 32'd0;
   localparam logic [DATA_W-1:0]  GAIN_P_RST   = 32'd184549;
   localparam logic [DATA_W-1:0]  GAIN_I_RST   = 32'd30199;
   localparam logic [DATA_W-1:0]  GAIN_D_RST   = 32'd0;
   localparam logic [LIMIT_W-1:0] DEADBAND_RST = 31'd40;
   localparam logic [LIMIT_W-1:0] SEP_RST      = 31'd1500;
   localparam logic [LIMIT_W-1:0] ILIM_RST     = 31'd4000;

   localparam logic [DATA_W-1:0] S32_MAX = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] S32_MIN = 32'h8000_0000;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_TARGET    = 3'd0,
      REG_GAIN_P    = 3'd1,
      REG_GAIN_I    = 3'd2,
      REG_GAIN_D    = 3'd3,
      REG_DEADBAND  = 3'd4,
      REG_SEP_LIMIT = 3'd5,
      REG_INT_LIMIT = 3'd6
   } csr_reg_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] err;
      logic signed [DATA_W-1:0] integ;
      logic signed [DIFF_W-1:0] dterm;
      logic                     in_db;
   } front_type;

   typedef struct packed {
      logic signed [PROD_W-1:0]   prod_p;
      logic signed [PROD_W-1:0]   prod_i;
      logic signed [PROD_D_W-1:0] prod_d;
      logic                       in_db;
   } prod_type;

endpackage

/* design/pospid_front.sv */
// ---------------------------------------------------------------------------
// pospid_front
// Error, deadband, integral separation and clamp, derivative difference.
// ---------------------------------------------------------------------------
module pospid_front (
   input  logic signed [pospid_pkg::DATA_W-1:0]  measured,
   input  logic signed [pospid_pkg::DATA_W-1:0]  target,
   input  logic        [pospid_pkg::LIMIT_W-1:0] deadband,
   input  logic        [pospid_pkg::LIMIT_W-1:0] sep_limit,
   input  logic        [pospid_pkg::LIMIT_W-1:0] int_limit,
   input  logic signed [pospid_pkg::DATA_W-1:0]  integral,
   input  logic signed [pospid_pkg::DATA_W-1:0]  last_error,
   output pospid_pkg::front_type                 result
);
   import pospid_pkg::*;

   logic signed [DIFF_W-1:0] diff;
   logic signed [DATA_W-1:0] err_sat;
   logic signed [DIFF_W-1:0] err_x;
   logic signed [DIFF_W-1:0] db_x;
   logic signed [DIFF_W-1:0] sep_x;
   logic signed [DIFF_W-1:0] lim_x;
   logic                     in_db;
   logic signed [DATA_W-1:0] err_db;
   logic signed [DIFF_W-1:0] err_db_x;
   logic signed [DATA_W-1:0] base;
   logic                     integrate;
   logic signed [DIFF_W-1:0] sum;
   logic signed [DIFF_W-1:0] clamped;

   always_comb begin
      diff = {target[DATA_W-1], target} - {measured[DATA_W-1], measured};
      if (diff[DIFF_W-1] != diff[DIFF_W-2]) begin
         err_sat = diff[DIFF_W-1] ? S32_MIN : S32_MAX;
      end else begin
         err_sat = diff[DATA_W-1:0];
      end

      err_x  = {err_sat[DATA_W-1], err_sat};
      db_x   = {2'b00, deadband};
      sep_x  = {2'b00, sep_limit};
      lim_x  = {2'b00, int_limit};
      in_db  = (err_x <= db_x) && (err_x >= -db_x);

      err_db   = in_db ? '0 : err_sat;
      base     = in_db ? '0 : integral;
      err_db_x = {err_db[DATA_W-1], err_db};

      integrate = (err_db_x > -sep_x) && (err_db_x < sep_x);
      sum       = {base[DATA_W-1], base} + err_db_x;
      if (sum > lim_x) begin
         clamped = lim_x;
      end else if (sum < -lim_x) begin
         clamped = -lim_x;
      end else begin
         clamped = sum;
      end

      result.err    = err_db;
      result.integ  = integrate ? clamped[DATA_W-1:0] : base;
      result.dterm  = err_db_x - {last_error[DATA_W-1], last_error};
      result.in_db  = in_db;
   end

endmodule

/* design/pospid_out.sv */
// ---------------------------------------------------------------------------
// pospid_out
// Sum of the three Q.24 products, round to Q.8 (ties up), saturate.
// ---------------------------------------------------------------------------
module pospid_out (
   input  pospid_pkg::prod_type                 prods,
   output logic [pospid_pkg::DATA_W-1:0]        drive
);
   import pospid_pkg::*;

   logic signed [SUM_W-1:0]   sum;
   logic signed [SHIFT_W-1:0] shifted;
   logic                      upper_ones;
   logic                      upper_zeros;

   always_comb begin
      sum = SUM_W'(prods.prod_p) + SUM_W'(prods.prod_i) + SUM_W'(prods.prod_d)
            + (SUM_W'(1) <<< (FRAC_DROP - 1));
      shifted     = sum[SUM_W-1:FRAC_DROP];
      upper_ones  = &shifted[SHIFT_W-1:DATA_W-1];
      upper_zeros = ~|shifted[SHIFT_W-1:DATA_W-1];
      if (upper_ones || upper_zeros) begin
         drive = shifted[DATA_W-1:0];
      end else if (shifted[SHIFT_W-1]) begin
         drive = S32_MIN;
      end else begin
         drive = S32_MAX;
      end
   end

endmodule

/* design/positional_pid_deadband_antiwindup.sv */
// ---------------------------------------------------------------------------
// positional_pid_deadband_antiwindup
// Positional PID for a position loop with deadband and integral separation.
// ---------------------------------------------------------------------------
// One measured position in, one drive value out. The block takes an item in
// every cycle unless all stages are full and the result is stalled; an item
// passes the input register, loaded at the accepting edge, then the
// error/integral, multiply and output registers, which offers its result.
// The integral and last error close their loop inside the error stage, which
// is what lets items follow back to back. A stall on the result side holds
// every full stage; empty slots are filled first, so an item is still taken
// while a finished result waits if a slot is empty. Configuration writes are
// always ready and are to be made only while the pipeline is empty.
module positional_pid_deadband_antiwindup (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [pospid_pkg::DATA_W-1:0] req_measured,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [pospid_pkg::DATA_W-1:0] rsp_drive,
   output logic                                 rsp_in_deadband,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pospid_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pospid_pkg::DATA_W-1:0]        csr_data
);
   import pospid_pkg::*;

   logic signed [DATA_W-1:0]  target_ff;
   logic signed [DATA_W-1:0]  gain_p_ff;
   logic signed [DATA_W-1:0]  gain_i_ff;
   logic signed [DATA_W-1:0]  gain_d_ff;
   logic        [LIMIT_W-1:0] deadband_ff;
   logic        [LIMIT_W-1:0] sep_limit_ff;
   logic        [LIMIT_W-1:0] int_limit_ff;

   logic signed [DATA_W-1:0]  integral_ff;
   logic signed [DATA_W-1:0]  last_error_ff;

   logic                      v0_ff, v1_ff, v2_ff, v3_ff;
   logic                      load0, load1, load2, load3;

   logic signed [DATA_W-1:0]  meas_ff;
   front_type                 front_in;
   front_type                 front_ff;
   prod_type                  prod_in;
   prod_type                  prod_ff;
   logic        [DATA_W-1:0]  drive_in;
   logic        [DATA_W-1:0]  drive_ff;
   logic                      in_db_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff    <= TARGET_RST;
         gain_p_ff    <= GAIN_P_RST;
         gain_i_ff    <= GAIN_I_RST;
         gain_d_ff    <= GAIN_D_RST;
         deadband_ff  <= DEADBAND_RST;
         sep_limit_ff <= SEP_RST;
         int_limit_ff <= ILIM_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_TARGET:    target_ff    <= csr_data;
            REG_GAIN_P:    gain_p_ff    <= csr_data;
            REG_GAIN_I:    gain_i_ff    <= csr_data;
            REG_GAIN_D:    gain_d_ff    <= csr_data;
            REG_DEADBAND:  deadband_ff  <= csr_data[LIMIT_W-1:0];
            REG_SEP_LIMIT: sep_limit_ff <= csr_data[LIMIT_W-1:0];
            REG_INT_LIMIT: int_limit_ff <= csr_data[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Pipeline advance: a stage loads when it is empty or its item moves on.
   assign load3     = !v3_ff || !rsp_stall;
   assign load2     = !v2_ff || load3;
   assign load1     = !v1_ff || load2;
   assign load0     = !v0_ff || load1;
   assign req_stall = !load0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff         <= 1'b0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         integral_ff   <= '0;
         last_error_ff <= '0;
      end else begin
         if (load0) v0_ff <= req_valid;
         if (load1) v1_ff <= v0_ff;
         if (load2) v2_ff <= v1_ff;
         if (load3) v3_ff <= v2_ff;
         if (load1 && v0_ff) begin
            integral_ff   <= front_in.integ;
            last_error_ff <= front_in.err;
         end
      end
   end

   pospid_front u_front (
      .measured   (meas_ff),
      .target     (target_ff),
      .deadband   (deadband_ff),
      .sep_limit  (sep_limit_ff),
      .int_limit  (int_limit_ff),
      .integral   (integral_ff),
      .last_error (last_error_ff),
      .result     (front_in)
   );

   always_comb begin
      prod_in.prod_p = gain_p_ff * front_ff.err;
      prod_in.prod_i = gain_i_ff * front_ff.integ;
      prod_in.prod_d = gain_d_ff * front_ff.dterm;
      prod_in.in_db  = front_ff.in_db;
   end

   pospid_out u_out (
      .prods (prod_ff),
      .drive (drive_in)
   );

   always_ff @(posedge clock) begin
      if (load0) meas_ff  <= req_measured;
      if (load1) front_ff <= front_in;
      if (load2) prod_ff  <= prod_in;
      if (load3) begin
         drive_ff <= drive_in;
         in_db_ff <= prod_ff.in_db;
      end
   end

   assign rsp_valid       = v3_ff;
   assign rsp_drive       = drive_ff;
   assign rsp_in_deadband = in_db_ff;

endmodule

/* design/pospid_checker.sv */
// ---------------------------------------------------------------------------
// pospid_checker
// Port-level checks of the position PID, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pospid_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic signed [pospid_pkg::DATA_W-1:0] rsp_drive,
   input logic                                 rsp_in_deadband
);
   import pospid_pkg::*;

   // Pipeline comes up empty and open
   `ASSERT_ALWAYS(a_reset_empty, reset |=> (!rsp_valid && !req_stall), "pipeline not empty")

   // Input only stalls when a result is held back
   `ASSERT_CLK(a_stall_source, (!rsp_valid || !rsp_stall) |-> !req_stall, "spurious stall")

   // Valid request never blocked by an idle output
   `ASSERT_CLK(a_open_when_idle, (req_valid && !rsp_valid) |-> !req_stall, "blocked while idle")

   `ASSERT_CLK(a_rsp_hold, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_drive) && $stable(rsp_in_deadband)), "result dropped")

endmodule

bind positional_pid_deadband_antiwindup pospid_checker u_pospid_checker (.*);
